/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define DRSTC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("drstc assertion failed");

// Property checked on every clock edge, reset included
`define DRSTC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("drstc assertion failed");

`endif

/* design/drstc_pkg.sv */
// Types, constants and the sample conversion shared by the relay timer files
package drstc_pkg;

   localparam int SAMPLE_W = 10;
   localparam int DEG_W    = 8;
   localparam int HOURS_W  = 7;
   localparam int MINS_W   = 6;
   localparam int SECS_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_ROOM_SETPOINT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PIPE_SETPOINT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_HOURS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RUN_MINUTES   = 2'd3;

   localparam logic [DEG_W-1:0]   RING_INIT  = 8'd21;
   localparam logic [DEG_W-1:0]   DEG_MAX    = 8'd255;
   localparam logic [SECS_W-1:0]  SECS_LAST  = 6'd59;
   localparam logic [MINS_W-1:0]  MINS_LAST  = 6'd59;
   localparam logic [HOURS_W-1:0] HOURS_LAST = 7'd99;

   // floor(x*500/1023) as (x * 500 * ceil(2^29/1023)) >> 29, exact for 10-bit x
   localparam int DEG_SHIFT = 29;
   localparam int DEG_PROD_W = 38;
   localparam logic [27:0] DEG_RECIP = 28'd262400500;

   typedef struct packed {
      logic [DEG_W-1:0]   room_setpoint;
      logic [DEG_W-1:0]   pipe_setpoint;
      logic [HOURS_W-1:0] run_hours;
      logic [MINS_W-1:0]  run_minutes;
   } cfg_type;

   // Stage loads for the lanes
   typedef struct packed {
      logic ld_conv;
      logic ld_ring;
      logic ld_avg;
   } lane_ctl_type;

   typedef struct packed {
      logic               room_relay;
      logic               pipe_relay;
      logic               timer_running;
      logic [DEG_W-1:0]   room_average;
      logic [DEG_W-1:0]   pipe_average;
      logic [HOURS_W-1:0] elapsed_hours;
      logic [MINS_W-1:0]  elapsed_minutes;
   } result_type;

   // Raw reading to whole degrees, saturated at 255
   function automatic logic [DEG_W-1:0] to_degrees(input logic [SAMPLE_W-1:0] raw);
      logic [DEG_PROD_W-1:0] prod;
      logic [8:0]            deg;
      prod = DEG_PROD_W'(raw) * DEG_PROD_W'(DEG_RECIP);
      deg  = prod[DEG_SHIFT +: 9];
      return deg[8] ? DEG_MAX : deg[DEG_W-1:0];
   endfunction

endpackage

/* design/drstc_if.sv */
// Channel interfaces: sample requests, results and configuration writes
interface drstc_req_if;
   logic                          valid;
   logic                          ready;
   logic [drstc_pkg::SAMPLE_W-1:0] room_sample;
   logic [drstc_pkg::SAMPLE_W-1:0] pipe_sample;
   modport source (output valid, output room_sample, output pipe_sample, input ready);
   modport sink (input valid, input room_sample, input pipe_sample, output ready);
endinterface

interface drstc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          room_relay;
   logic                          pipe_relay;
   logic                          timer_running;
   logic [drstc_pkg::DEG_W-1:0]   room_average;
   logic [drstc_pkg::DEG_W-1:0]   pipe_average;
   logic [drstc_pkg::HOURS_W-1:0] elapsed_hours;
   logic [drstc_pkg::MINS_W-1:0]  elapsed_minutes;
   modport source (output valid, output room_relay, output pipe_relay,
                   output timer_running, output room_average, output pipe_average,
                   output elapsed_hours, output elapsed_minutes, input ready);
   modport sink (input valid, input room_relay, input pipe_relay,
                 input timer_running, input room_average, input pipe_average,
                 input elapsed_hours, input elapsed_minutes, output ready);
endinterface

interface drstc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [drstc_pkg::CSR_IDX_W-1:0]  index;
   logic [drstc_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/drstc_lane.sv */
// One sensor lane: conversion, averaging ring, running sum and average
module drstc_lane #(
   parameter int AVG_DEPTH = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  drstc_pkg::lane_ctl_type       ctl,
   input  logic [drstc_pkg::SAMPLE_W-1:0] sample,
   output logic [drstc_pkg::DEG_W-1:0]   average
);
   import drstc_pkg::*;

   localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W  = $clog2(255 * AVG_DEPTH + 1);
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP  = (2 ** RECIP_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam int PROD_W = SUM_W + RECIP_SHIFT + 1;

   logic [DEG_W-1:0] deg_ff;
   logic [DEG_W-1:0] ring_ff [AVG_DEPTH];
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [PROD_W-1:0] avg_prod;
   logic [DEG_W-1:0] avg_ff;

   // Conversion stage
   always_ff @(posedge clock) begin
      if (ctl.ld_conv) begin
         deg_ff <= to_degrees(sample);
      end
   end

   // Ring stage: replace the oldest entry and update the running sum
   assign sum_in = sum_ff - SUM_W'(ring_ff[idx_ff]) + SUM_W'(deg_ff);
   assign idx_in = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= RING_INIT;
         end
         idx_ff <= '0;
         sum_ff <= SUM_W'(21 * AVG_DEPTH);
      end else if (ctl.ld_ring) begin
         ring_ff[idx_ff] <= deg_ff;
         idx_ff          <= idx_in;
         sum_ff          <= sum_in;
      end
   end

   // Average stage: divide by the depth through a reciprocal multiply
   assign avg_prod = PROD_W'(sum_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (ctl.ld_avg) begin
         avg_ff <= avg_prod[RECIP_SHIFT +: DEG_W];
      end
   end

   assign average = avg_ff;

endmodule

/* design/drstc_merge.sv */
// Merge stage: relay decisions, run timer and the result register
module drstc_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ld,
   input  drstc_pkg::cfg_type          cfg,
   input  logic [drstc_pkg::DEG_W-1:0] room_avg,
   input  logic [drstc_pkg::DEG_W-1:0] pipe_avg,
   output drstc_pkg::result_type       result
);
   import drstc_pkg::*;

   logic               timer_on_ff, timer_on_in;
   logic               pipe_relay_ff, pipe_relay_in;
   logic [SECS_W-1:0]  secs_ff, secs_in;
   logic [MINS_W-1:0]  mins_ff, mins_in;
   logic [HOURS_W-1:0] hours_ff, hours_in;
   logic               started;
   result_type         result_ff;

   // Timer advance, start test and stop test
   always_comb begin
      secs_in  = '0;
      mins_in  = '0;
      hours_in = '0;
      if (timer_on_ff) begin
         secs_in  = secs_ff + 1'b1;
         mins_in  = mins_ff;
         hours_in = hours_ff;
         if (secs_ff >= SECS_LAST) begin
            secs_in = '0;
            mins_in = mins_ff + 1'b1;
            if (mins_ff >= MINS_LAST) begin
               mins_in  = '0;
               hours_in = (hours_ff >= HOURS_LAST) ? '0 : hours_ff + 1'b1;
            end
         end
      end
      started       = (pipe_avg >= cfg.pipe_setpoint);
      pipe_relay_in = timer_on_ff ? pipe_relay_ff : started;
      timer_on_in   = timer_on_ff | started;
      if (mins_in == cfg.run_minutes && hours_in == cfg.run_hours) begin
         timer_on_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_on_ff   <= 1'b0;
         pipe_relay_ff <= 1'b0;
         secs_ff       <= '0;
         mins_ff       <= '0;
         hours_ff      <= '0;
      end else if (ld) begin
         timer_on_ff   <= timer_on_in;
         pipe_relay_ff <= pipe_relay_in;
         secs_ff       <= secs_in;
         mins_ff       <= mins_in;
         hours_ff      <= hours_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ld) begin
         result_ff.room_relay      <= (room_avg <= cfg.room_setpoint);
         result_ff.pipe_relay      <= pipe_relay_in;
         result_ff.timer_running   <= timer_on_in;
         result_ff.room_average    <= room_avg;
         result_ff.pipe_average    <= pipe_avg;
         result_ff.elapsed_hours   <= hours_in;
         result_ff.elapsed_minutes <= mins_in;
      end
   end

   assign result = result_ff;

endmodule

/* design/dual_sensor_relay_timer_control_top.sv */
// Throughput: one transaction per cycle while results are taken; every stage
// stalls on its own, so a request is taken while a finished result waits, as
// long as stage one is free. Reset (synchronous) fills both rings with 21
// degrees, sets the sums to match, stops and clears the run timer, opens the
// pipe relay and zeroes the configuration registers and the stage valid flags.
module dual_sensor_relay_timer_control_top #(
   parameter int AVG_DEPTH = 10
) (
   input logic         clock,
   input logic         reset,
   drstc_req_if.sink   req_chan,
   drstc_rsp_if.source rsp_chan,
   drstc_csr_if.sink   csr_chan
);
   import drstc_pkg::*;

   cfg_type      cfg_ff;
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         en1, en2, en3, en4;
   lane_ctl_type lane_ctl;
   logic [DEG_W-1:0] room_avg, pipe_avg;
   result_type   result;

   // Configuration registers, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_ROOM_SETPOINT: cfg_ff.room_setpoint <= csr_chan.data;
            REG_PIPE_SETPOINT: cfg_ff.pipe_setpoint <= csr_chan.data;
            REG_RUN_HOURS:     cfg_ff.run_hours     <= csr_chan.data[HOURS_W-1:0];
            REG_RUN_MINUTES:   cfg_ff.run_minutes   <= csr_chan.data[MINS_W-1:0];
         endcase
      end
   end

   // Stage enables: a stage moves when empty or when the next one moves
   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready   = en1;
   assign lane_ctl.ld_conv = en1 && req_chan.valid;
   assign lane_ctl.ld_ring = en2 && v1_ff;
   assign lane_ctl.ld_avg  = en3 && v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Two lanes side by side
   drstc_lane #(.AVG_DEPTH(AVG_DEPTH)) u_room_lane (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (req_chan.room_sample),
      .average (room_avg)
   );

   drstc_lane #(.AVG_DEPTH(AVG_DEPTH)) u_pipe_lane (
      .clock   (clock),
      .reset   (reset),
      .ctl     (lane_ctl),
      .sample  (req_chan.pipe_sample),
      .average (pipe_avg)
   );

   drstc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ld       (en4 && v3_ff),
      .cfg      (cfg_ff),
      .room_avg (room_avg),
      .pipe_avg (pipe_avg),
      .result   (result)
   );

   // Result channel
   assign rsp_chan.valid           = v4_ff;
   assign rsp_chan.room_relay      = result.room_relay;
   assign rsp_chan.pipe_relay      = result.pipe_relay;
   assign rsp_chan.timer_running   = result.timer_running;
   assign rsp_chan.room_average    = result.room_average;
   assign rsp_chan.pipe_average    = result.pipe_average;
   assign rsp_chan.elapsed_hours   = result.elapsed_hours;
   assign rsp_chan.elapsed_minutes = result.elapsed_minutes;

endmodule

/* design/drstc_checker.sv */
// Port-level checks for the relay timer top level, bound to it
`include "assert_macros.svh"

module drstc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_pipe_relay,
   input logic       rsp_timer_running,
   input logic [6:0] rsp_elapsed_hours,
   input logic [5:0] rsp_elapsed_minutes
);

   // A pending result stays offered until taken
   `DRSTC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // A running timer implies the pipe relay closed when it started
   `DRSTC_ASSERT(a_run_relay, clock, reset, rsp_valid && rsp_timer_running |-> rsp_pipe_relay)

   // Elapsed time stays within its clock ranges
   `DRSTC_ASSERT(a_time_range, clock, reset, rsp_valid |-> (rsp_elapsed_minutes < 6'd60) && (rsp_elapsed_hours < 7'd100))

   // No result is offered straight after reset
   `DRSTC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind dual_sensor_relay_timer_control_top drstc_checker u_drstc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_pipe_relay      (rsp_chan.pipe_relay),
   .rsp_timer_running   (rsp_chan.timer_running),
   .rsp_elapsed_hours   (rsp_chan.elapsed_hours),
   .rsp_elapsed_minutes (rsp_chan.elapsed_minutes)
);
